/* design/pwfp_pkg.sv */
// shared types, constants and helpers of the protobuf wire field parser
package pwfp_pkg;

  localparam int LEN_BITS_DEF = 32;
  localparam int GRP_W = 4;
  localparam int SEL_W = 3;

  // last 7-bit group index of a 64-bit varint
  localparam logic [GRP_W-1:0] GRP_LAST = 4'd9;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  localparam logic [SEL_W-1:0] SEL_NONE = 3'd0;
  localparam logic [SEL_W-1:0] SEL_SOURCE = 3'd1;
  localparam logic [SEL_W-1:0] SEL_DEST = 3'd2;
  localparam logic [SEL_W-1:0] SEL_NAMESPACE = 3'd3;
  localparam logic [SEL_W-1:0] SEL_PAYLOAD = 3'd4;

  localparam logic [3:0] FIELD_SOURCE = 4'd2;
  localparam logic [3:0] FIELD_DEST = 4'd3;
  localparam logic [3:0] FIELD_NAMESPACE = 4'd4;
  localparam logic [3:0] FIELD_PAYLOAD = 4'd6;

  localparam logic [3:0] FIXED64_BYTES = 4'd8;
  localparam logic [3:0] FIXED32_BYTES = 4'd4;

  typedef enum logic [5:0] {
    MODE_TAG   = 6'b000001,
    MODE_VALUE = 6'b000010,
    MODE_LEN   = 6'b000100,
    MODE_DATA  = 6'b001000,
    MODE_FIXED = 6'b010000,
    MODE_HALT  = 6'b100000
  } mode_t;

  // string select for a field number that fits in four bits
  function automatic logic [SEL_W-1:0] select_of(input logic [3:0] field);
    logic [SEL_W-1:0] sel;
    sel = SEL_NONE;
    if (field == FIELD_SOURCE) sel = SEL_SOURCE;
    else if (field == FIELD_DEST) sel = SEL_DEST;
    else if (field == FIELD_NAMESPACE) sel = SEL_NAMESPACE;
    else if (field == FIELD_PAYLOAD) sel = SEL_PAYLOAD;
    return sel;
  endfunction

endpackage

/* design/pwfp_if.sv */
// valid/ready channel interfaces for body bytes and parse results
interface pwfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface pwfp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        byte_valid;
  logic [7:0]                  out_byte;
  logic [pwfp_pkg::SEL_W-1:0]  string_sel;
  logic                        string_end;
  logic                        body_done;
  logic                        parse_status;

  modport source (output valid, output byte_valid, output out_byte, output string_sel,
                  output string_end, output body_done, output parse_status, input ready);
  modport sink (input valid, input byte_valid, input out_byte, input string_sel,
                input string_end, input body_done, input parse_status, output ready);
endinterface

/* design/protobuf_wire_field_parser.sv */
// Protobuf wire-format field parser: one body byte in, one result out.
// Input channel in_ch carries data_byte and is_last (set on the final body byte).
// Output channel out_ch carries exactly one result per accepted byte:
// byte_valid/out_byte for a byte of a selected string (fields 2, 3, 4, 6),
// string_sel and string_end to frame strings (an empty string gives one end
// marker), and body_done/parse_status on the result of the final byte.
// Strings already passed must be dropped by the consumer on a malformed status.
// From acceptance a byte passes an input register, then the varint/field decode
// into the result register. Throughput is one byte per cycle while the receiver
// does not stall; the running parse state updates as each byte advances.
// The input register takes a new byte while a result waits in the output
// register; when the receiver stalls both fill and ready drops, nothing lost.
// Reset (rst, synchronous) empties both registers and puts the parser back to
// expecting a tag; the state also returns there after every final byte.
// LEN_BITS sets the widest accepted string length; longer lengths are errors.
module protobuf_wire_field_parser #(
  parameter int LEN_BITS = pwfp_pkg::LEN_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  pwfp_in_if.sink     in_ch,
  pwfp_out_if.source  out_ch
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // parse state
  pwfp_pkg::mode_t             mode, mode_next;
  logic [LEN_BITS-1:0]         accum, accum_next;
  logic                        ovf, ovf_next;
  logic [pwfp_pkg::GRP_W-1:0]  grp, grp_next;
  logic [LEN_BITS-1:0]         remain, remain_next;
  logic [pwfp_pkg::SEL_W-1:0]  field, field_next;
  logic                        err, err_next;

  // result of the byte in the input register
  logic                        r_byte_valid;
  logic [7:0]                  r_out_byte;
  logic [pwfp_pkg::SEL_W-1:0]  r_sel;
  logic                        r_end;
  logic                        r_done;
  logic                        r_status;

  logic        advance;
  logic [6:0]  shamt;
  logic [63:0] contrib;
  logic        contrib_hi_nz;
  logic [LEN_BITS-1:0] accum_or;
  logic        ovf_or;
  logic [LEN_BITS-1:0] remain_dec;
  logic [2:0]  wire_type;
  logic        tag_hi_nz;

  assign advance = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  assign shamt = 7'(grp) * 7'd7;
  assign contrib = 64'(s1_byte[6:0]) << shamt;

  if (LEN_BITS < 64) begin : g_ovf
    assign contrib_hi_nz = |contrib[63:LEN_BITS];
  end else begin : g_no_ovf
    assign contrib_hi_nz = 1'b0;
  end

  assign accum_or = accum | contrib[LEN_BITS-1:0];
  assign ovf_or = ovf | contrib_hi_nz;
  assign remain_dec = remain - LEN_BITS'(1);
  assign wire_type = accum_or[2:0];
  assign tag_hi_nz = (|accum_or[LEN_BITS-1:7]) || ovf_or;

  always_comb begin
    mode_next = mode;
    accum_next = accum;
    ovf_next = ovf;
    grp_next = grp;
    remain_next = remain;
    field_next = field;
    err_next = err;
    r_byte_valid = 1'b0;
    r_out_byte = 8'd0;
    r_sel = pwfp_pkg::SEL_NONE;
    r_end = 1'b0;
    r_done = 1'b0;
    r_status = 1'b0;

    unique case (mode)
      pwfp_pkg::MODE_TAG, pwfp_pkg::MODE_VALUE, pwfp_pkg::MODE_LEN: begin
        accum_next = accum_or;
        ovf_next = ovf_or;
        if (!s1_byte[7]) begin
          accum_next = '0;
          ovf_next = 1'b0;
          grp_next = '0;
          if (mode == pwfp_pkg::MODE_TAG) begin
            field_next = tag_hi_nz ? pwfp_pkg::SEL_NONE : pwfp_pkg::select_of(accum_or[6:3]);
            unique case (wire_type)
              pwfp_pkg::WIRE_VARINT: mode_next = pwfp_pkg::MODE_VALUE;
              pwfp_pkg::WIRE_LEN: mode_next = pwfp_pkg::MODE_LEN;
              pwfp_pkg::WIRE_FIXED64: begin
                mode_next = pwfp_pkg::MODE_FIXED;
                remain_next = LEN_BITS'(pwfp_pkg::FIXED64_BYTES);
              end
              pwfp_pkg::WIRE_FIXED32: begin
                mode_next = pwfp_pkg::MODE_FIXED;
                remain_next = LEN_BITS'(pwfp_pkg::FIXED32_BYTES);
              end
              default: begin
                err_next = 1'b1;
                mode_next = pwfp_pkg::MODE_HALT;
              end
            endcase
            // body may not end right before a value or a length
            if (s1_last && (wire_type == pwfp_pkg::WIRE_VARINT ||
                            wire_type == pwfp_pkg::WIRE_LEN)) begin
              err_next = 1'b1;
              mode_next = pwfp_pkg::MODE_HALT;
            end
          end else if (mode == pwfp_pkg::MODE_VALUE) begin
            mode_next = pwfp_pkg::MODE_TAG;
          end else if (ovf_or) begin
            err_next = 1'b1;
            mode_next = pwfp_pkg::MODE_HALT;
          end else if (accum_or == '0) begin
            // empty string: one end marker
            if (field != pwfp_pkg::SEL_NONE) begin
              r_sel = field;
              r_end = 1'b1;
            end
            mode_next = pwfp_pkg::MODE_TAG;
          end else begin
            remain_next = accum_or;
            mode_next = pwfp_pkg::MODE_DATA;
            if (s1_last) begin
              err_next = 1'b1;
              mode_next = pwfp_pkg::MODE_HALT;
            end
          end
        end else begin
          grp_next = grp + pwfp_pkg::GRP_W'(1);
          if (grp == pwfp_pkg::GRP_LAST || s1_last) begin
            err_next = 1'b1;
            mode_next = pwfp_pkg::MODE_HALT;
          end
        end
      end
      pwfp_pkg::MODE_DATA: begin
        remain_next = remain_dec;
        if (field != pwfp_pkg::SEL_NONE) begin
          r_byte_valid = 1'b1;
          r_out_byte = s1_byte;
          r_sel = field;
          r_end = (remain_dec == '0);
        end
        if (remain_dec == '0) begin
          mode_next = pwfp_pkg::MODE_TAG;
        end else if (s1_last) begin
          err_next = 1'b1;
          mode_next = pwfp_pkg::MODE_HALT;
        end
      end
      pwfp_pkg::MODE_FIXED: begin
        remain_next = remain_dec;
        if (remain_dec == '0) mode_next = pwfp_pkg::MODE_TAG;
      end
      default: begin
        // halted: wait for the final byte
      end
    endcase

    if (s1_last) begin
      r_done = 1'b1;
      r_status = err_next;
      mode_next = pwfp_pkg::MODE_TAG;
      accum_next = '0;
      ovf_next = 1'b0;
      grp_next = '0;
      remain_next = '0;
      field_next = pwfp_pkg::SEL_NONE;
      err_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.data_byte;
      s1_last <= in_ch.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pwfp_pkg::MODE_TAG;
      accum <= '0;
      ovf <= 1'b0;
      grp <= '0;
      remain <= '0;
      field <= pwfp_pkg::SEL_NONE;
      err <= 1'b0;
    end else if (advance) begin
      mode <= mode_next;
      accum <= accum_next;
      ovf <= ovf_next;
      grp <= grp_next;
      remain <= remain_next;
      field <= field_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.byte_valid <= r_byte_valid;
      out_ch.out_byte <= r_out_byte;
      out_ch.string_sel <= r_sel;
      out_ch.string_end <= r_end;
      out_ch.body_done <= r_done;
      out_ch.parse_status <= r_status;
    end
  end

endmodule

/* design/pwfp_checker.sv */
// port-level checks of the protobuf wire field parser, bound to the top level
module pwfp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        byte_valid,
  input logic [7:0]                  out_byte,
  input logic [pwfp_pkg::SEL_W-1:0]  string_sel,
  input logic                        string_end,
  input logic                        body_done,
  input logic                        parse_status
);

  // a status only comes with the end of a body
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status |-> body_done)
    else $error("parse_status set without body_done");

  // string bytes and end markers always name a selected string
  a_sel_on_string: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_valid || string_end) |->
      (string_sel != pwfp_pkg::SEL_NONE) && (string_sel <= pwfp_pkg::SEL_PAYLOAD))
    else $error("string transaction without a valid string_sel");

  // non-string transactions carry a clean payload
  a_idle_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> (out_byte == 8'd0))
    else $error("out_byte nonzero without byte_valid");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(string_sel) &&
      $stable(body_done) && $stable(parse_status))
    else $error("result changed while stalled");

endmodule

bind protobuf_wire_field_parser pwfp_checker u_pwfp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .byte_valid   (out_ch.byte_valid),
  .out_byte     (out_ch.out_byte),
  .string_sel   (out_ch.string_sel),
  .string_end   (out_ch.string_end),
  .body_done    (out_ch.body_done),
  .parse_status (out_ch.parse_status)
);

/* tb/sv/protobuf_wire_field_parser_tb.sv */
// self-checking testbench of the protobuf wire field parser with random flow control
`timescale 1ns / 100ps

module protobuf_wire_field_parser_tb;

  localparam int STALL_LIMIT = 2000;
  localparam logic [63:0] LEN_LIMIT = (64'd1 << pwfp_pkg::LEN_BITS_DEF) - 64'd1;
  localparam int RANDOM_ITEMS = 1700;

  // wire types the parser must reject
  localparam logic [2:0] WIRE_SGROUP = 3'd3;
  localparam logic [2:0] WIRE_EGROUP = 3'd4;
  localparam logic [2:0] WIRE_RSVD6 = 3'd6;
  localparam logic [2:0] WIRE_RSVD7 = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_byte_t;

  typedef struct packed {
    logic                       byte_valid;
    logic [7:0]                 out_byte;
    logic [pwfp_pkg::SEL_W-1:0] string_sel;
    logic                       string_end;
    logic                       body_done;
    logic                       parse_status;
  } parse_result_t;

  logic clk;
  logic rst;

  pwfp_in_if in_ch ();
  pwfp_out_if out_ch ();

  protobuf_wire_field_parser uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser state tracked alongside the block
  pwfp_pkg::mode_t            pmode;
  logic [63:0]                accum;
  logic [6:0]                 shift;
  logic [63:0]                remaining;
  logic [pwfp_pkg::SEL_W-1:0] cur_sel;
  logic                       malformed;

  logic [7:0]    body[$];
  body_byte_t    pending_bytes[$];
  parse_result_t parse_results_due[$];
  parse_result_t oldest;

  int unsigned src_wait;
  int unsigned sink_wait;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned stall_cycles;
  int unsigned failures;
  int unsigned bodies_done;
  int unsigned bad_bodies;
  int unsigned string_bytes;
  int unsigned empty_markers;

  task automatic clear_parse_state();
    pmode = pwfp_pkg::MODE_TAG;
    accum = '0;
    shift = '0;
    remaining = '0;
    cur_sel = pwfp_pkg::SEL_NONE;
    malformed = 1'b0;
  endtask

  function automatic void flag_malformed();
    malformed = 1'b1;
    pmode = pwfp_pkg::MODE_HALT;
  endfunction

  function automatic logic [pwfp_pkg::SEL_W-1:0] string_select(input logic [63:0] fnum);
    if (fnum == 64'(pwfp_pkg::FIELD_SOURCE)) return pwfp_pkg::SEL_SOURCE;
    if (fnum == 64'(pwfp_pkg::FIELD_DEST)) return pwfp_pkg::SEL_DEST;
    if (fnum == 64'(pwfp_pkg::FIELD_NAMESPACE)) return pwfp_pkg::SEL_NAMESPACE;
    if (fnum == 64'(pwfp_pkg::FIELD_PAYLOAD)) return pwfp_pkg::SEL_PAYLOAD;
    return pwfp_pkg::SEL_NONE;
  endfunction

  // next parse result for one body byte
  task automatic predict_parse(input logic [7:0] b, input logic last);
    parse_result_t r;
    logic [63:0] v;
    r = '0;
    case (pmode)
      pwfp_pkg::MODE_TAG, pwfp_pkg::MODE_VALUE, pwfp_pkg::MODE_LEN: begin
        accum = accum | ({57'd0, b[6:0]} << shift[5:0]);
        if (!b[7]) begin
          v = accum;
          accum = '0;
          shift = '0;
          if (pmode == pwfp_pkg::MODE_TAG) begin
            cur_sel = string_select(v >> 3);
            case (v[2:0])
              pwfp_pkg::WIRE_VARINT: pmode = pwfp_pkg::MODE_VALUE;
              pwfp_pkg::WIRE_LEN: pmode = pwfp_pkg::MODE_LEN;
              pwfp_pkg::WIRE_FIXED64: begin
                pmode = pwfp_pkg::MODE_FIXED;
                remaining = 64'(pwfp_pkg::FIXED64_BYTES);
              end
              pwfp_pkg::WIRE_FIXED32: begin
                pmode = pwfp_pkg::MODE_FIXED;
                remaining = 64'(pwfp_pkg::FIXED32_BYTES);
              end
              default: flag_malformed();
            endcase
            // body cut right after a tag that needs more bytes
            if (last && (pmode == pwfp_pkg::MODE_VALUE || pmode == pwfp_pkg::MODE_LEN))
              flag_malformed();
          end else if (pmode == pwfp_pkg::MODE_VALUE) begin
            pmode = pwfp_pkg::MODE_TAG;
          end else if (v > LEN_LIMIT) begin
            flag_malformed();
          end else if (v == 64'd0) begin
            if (cur_sel != pwfp_pkg::SEL_NONE) begin
              r.string_sel = cur_sel;
              r.string_end = 1'b1;
            end
            pmode = pwfp_pkg::MODE_TAG;
          end else begin
            remaining = v;
            pmode = pwfp_pkg::MODE_DATA;
            if (last) flag_malformed();
          end
        end else begin
          shift = shift + 7'd7;
          if (shift > 7'd63 || last) flag_malformed();
        end
      end
      pwfp_pkg::MODE_DATA: begin
        remaining = remaining - 64'd1;
        if (cur_sel != pwfp_pkg::SEL_NONE) begin
          r.byte_valid = 1'b1;
          r.out_byte = b;
          r.string_sel = cur_sel;
          r.string_end = (remaining == 64'd0);
        end
        if (remaining == 64'd0) pmode = pwfp_pkg::MODE_TAG;
        else if (last) flag_malformed();
      end
      pwfp_pkg::MODE_FIXED: begin
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) pmode = pwfp_pkg::MODE_TAG;
      end
      default: ;
    endcase
    if (last) begin
      r.body_done = 1'b1;
      r.parse_status = malformed;
      clear_parse_state();
    end
    parse_results_due.push_back(r);
  endtask

  // base-128 encoding; the long form always spends ten bytes and fills bits past 63
  task automatic add_varint(input logic [63:0] v, input bit long_form = 1'b0);
    logic [63:0] rest;
    logic [7:0] grp;
    rest = v;
    if (long_form) begin
      repeat (9) begin
        body.push_back({1'b1, rest[6:0]});
        rest = rest >> 7;
      end
      grp = {1'b0, 6'd0, rest[0]};
      grp[6:1] = 6'($urandom_range(0, 63));
      body.push_back(grp);
    end else begin
      do begin
        grp = {1'b0, rest[6:0]};
        rest = rest >> 7;
        if (rest != 64'd0) grp[7] = 1'b1;
        body.push_back(grp);
      end while (rest != 64'd0);
    end
  endtask

  task automatic add_tag(input logic [63:0] fnum, input logic [2:0] wire_type,
                         input bit long_form = 1'b0);
    add_varint({fnum[60:0], wire_type}, long_form);
  endtask

  task automatic queue_body(input int n);
    for (int i = 0; i < n; i++) pending_bytes.push_back({body[i], i == n - 1});
    body.delete();
  endtask

  function automatic logic [63:0] selected_field();
    case ($urandom_range(0, 3))
      0: return 64'(pwfp_pkg::FIELD_SOURCE);
      1: return 64'(pwfp_pkg::FIELD_DEST);
      2: return 64'(pwfp_pkg::FIELD_NAMESPACE);
      default: return 64'(pwfp_pkg::FIELD_PAYLOAD);
    endcase
  endfunction

  function automatic logic [63:0] other_field();
    case ($urandom_range(0, 4))
      0, 1: return 64'($urandom_range(1, 15));
      2: return 64'($urandom_range(16, 5000));
      // low bits name a string field, a high bit makes it a different number
      3: return selected_field() | (64'd1 << $urandom_range(4, 60));
      default: return {$urandom, $urandom} >> 3;
    endcase
  endfunction

  function automatic logic [63:0] random_value();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic int string_length();
    if ($urandom_range(0, 7) == 0) return $urandom_range(20, 40);
    return $urandom_range(0, 8);
  endfunction

  task automatic build_random_body();
    int nfields;
    int kind;
    int len;
    logic [2:0] bad_wire;
    logic [63:0] huge_len;
    nfields = $urandom_range(1, 6);
    repeat (nfields) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_tag(selected_field(), pwfp_pkg::WIRE_LEN, $urandom_range(0, 15) == 0);
        len = string_length();
        add_varint(64'(len), $urandom_range(0, 15) == 0);
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 44) begin
        add_tag(other_field(), pwfp_pkg::WIRE_LEN, $urandom_range(0, 15) == 0);
        len = string_length();
        add_varint(64'(len));
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 56) begin
        add_tag($urandom_range(0, 2) == 0 ? selected_field() : other_field(),
                pwfp_pkg::WIRE_VARINT);
        add_varint(random_value(), $urandom_range(0, 7) == 0);
      end else if (kind < 64) begin
        add_tag($urandom_range(0, 2) == 0 ? selected_field() : other_field(),
                pwfp_pkg::WIRE_FIXED64);
        repeat (8) body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 72) begin
        add_tag($urandom_range(0, 2) == 0 ? selected_field() : other_field(),
                pwfp_pkg::WIRE_FIXED32);
        repeat (4) body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
        add_tag($urandom_range(0, 3) == 0 ? other_field() : selected_field(),
                pwfp_pkg::WIRE_LEN);
        add_varint(64'd0, $urandom_range(0, 3) == 0);
      end else if (kind < 87) begin
        case ($urandom_range(0, 3))
          0: bad_wire = WIRE_SGROUP;
          1: bad_wire = WIRE_EGROUP;
          2: bad_wire = WIRE_RSVD6;
          default: bad_wire = WIRE_RSVD7;
        endcase
        add_tag($urandom_range(0, 1) ? selected_field() : other_field(), bad_wire);
      end else if (kind < 90) begin
        // more than ten varint bytes
        repeat (10) body.push_back(8'h80 | 8'($urandom_range(0, 127)));
        body.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 94) begin
        case ($urandom_range(0, 2))
          0: huge_len = LEN_LIMIT;
          1: huge_len = LEN_LIMIT + 64'd1;
          default: huge_len = LEN_LIMIT + 64'd1 + (random_value() >> 1);
        endcase
        add_tag(selected_field(), pwfp_pkg::WIRE_LEN);
        add_varint(huge_len);
      end else begin
        repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
      end
    end
    // some bodies are cut off at a random point
    if ($urandom_range(0, 6) == 0) queue_body($urandom_range(1, body.size()));
    else queue_body(body.size());
  endtask

  function automatic int unsigned idle_draw(input int unsigned n);
    // every third stretch of transactions runs without gaps
    if (((n / 128) % 3) == 2) return 0;
    return $urandom_range(0, 5);
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'd0;
      in_ch.is_last <= 1'b0;
      src_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_parse(in_ch.data_byte, in_ch.is_last);
        bytes_sent++;
        src_wait = idle_draw(bytes_sent);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_wait > 0) begin
          src_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= pending_bytes[0].data;
          in_ch.is_last <= pending_bytes[0].last;
          pending_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (parse_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time,
                   {out_ch.byte_valid, out_ch.out_byte, out_ch.string_sel,
                    out_ch.string_end, out_ch.body_done, out_ch.parse_status});
          failures++;
        end else begin
          oldest = parse_results_due.pop_front();
          compare_field("byte_valid", 64'(oldest.byte_valid), 64'(out_ch.byte_valid));
          compare_field("out_byte", 64'(oldest.out_byte), 64'(out_ch.out_byte));
          compare_field("string_sel", 64'(oldest.string_sel), 64'(out_ch.string_sel));
          compare_field("string_end", 64'(oldest.string_end), 64'(out_ch.string_end));
          compare_field("body_done", 64'(oldest.body_done), 64'(out_ch.body_done));
          compare_field("parse_status", 64'(oldest.parse_status),
                        64'(out_ch.parse_status));
          if (oldest.byte_valid) string_bytes++;
          if (oldest.string_end && !oldest.byte_valid) empty_markers++;
          if (oldest.body_done) begin
            bodies_done++;
            if (oldest.parse_status) bad_bodies++;
          end
        end
        sink_wait = idle_draw(results_seen);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results still due", $time,
                 stall_cycles, parse_results_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
    bytes_sent = 0;
    results_seen = 0;
    stall_cycles = 0;
    failures = 0;
    bodies_done = 0;
    bad_bodies = 0;
    string_bytes = 0;
    empty_markers = 0;
    clear_parse_state();

    // empty source string
    add_tag(64'(pwfp_pkg::FIELD_SOURCE), pwfp_pkg::WIRE_LEN);
    add_varint(64'd0);
    queue_body(body.size());
    // two-byte destination string with both extreme byte values
    add_tag(64'(pwfp_pkg::FIELD_DEST), pwfp_pkg::WIRE_LEN);
    add_varint(64'd2);
    body.push_back(8'hFF);
    body.push_back(8'h00);
    queue_body(body.size());
    // illegal wire type
    add_tag(64'd1, WIRE_SGROUP);
    body.push_back(8'h55);
    queue_body(body.size());
    // body ends inside a varint value
    add_tag(64'd5, pwfp_pkg::WIRE_VARINT);
    body.push_back(8'hFF);
    queue_body(body.size());
    // body ends inside a fixed64 skip, which is still fine
    add_tag(64'd1, pwfp_pkg::WIRE_FIXED64);
    body.push_back(8'h01);
    body.push_back(8'h02);
    queue_body(body.size());
    // body ends inside payload string data
    add_tag(64'(pwfp_pkg::FIELD_PAYLOAD), pwfp_pkg::WIRE_LEN);
    add_varint(64'd3);
    body.push_back(8'hAA);
    queue_body(body.size());
    // overlong tag varint
    repeat (10) body.push_back(8'h80 | 8'($urandom_range(0, 127)));
    queue_body(body.size());

    while (pending_bytes.size() < RANDOM_ITEMS) build_random_body();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_ch.valid || parse_results_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d results for %0d bytes over %0d bodies, %0d of them malformed",
             results_seen, bytes_sent, bodies_done, bad_bodies);
    $display("string traffic: %0d payload bytes, %0d empty string markers",
             string_bytes, empty_markers);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
